// File: hdl/ppdc_pkg.sv
package ppdc_pkg;

  localparam int unsigned WrapSpan = 8192;
  localparam int unsigned WrapHalf = WrapSpan / 2;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned GainW  = 24;
  localparam int unsigned ErrW   = 18;
  localparam int unsigned DiffW  = 19;
  localparam int unsigned Diff2W = 21;
  localparam int unsigned MulW   = 25;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned TW     = 45;
  localparam int unsigned IntW   = 32;
  localparam int unsigned DerW   = 48;
  localparam int unsigned DoutW  = 50;
  localparam int unsigned AccW   = 52;
  localparam int unsigned DaccW  = 66;

  typedef enum logic [2:0] {
    RegMode,
    RegKp,
    RegKi,
    RegKd,
    RegMaxOut,
    RegMaxIout,
    RegISep,
    RegGamma
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StMulKd,
    StMulKp,
    StMulKi,
    StInteg,
    StDer2,
    StDer3,
    StDer4,
    StDerSum,
    StDout,
    StFinish
  } state_e;

  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic               clear;
  } pid_in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               saturated;
  } pid_out_t;

endpackage

// File: hdl/pid_position_delta_controller.sv
// PID controller, positional or incremental, Q16.16 internal arithmetic.
// Input channel: in_valid_i / in_stall_o carries measured, target and clear.
// Output channel: out_valid_o / out_stall_i carries drive and saturated,
// one result per input transfer, in order.
// Registers (mode, gains, limits, separation, gamma) sit on the APB port at
// byte address 4*index; write them only while the block is idle.
// Timing: one transfer at a time. Steps in order: Kd, Kp and Ki products,
// integral, derivative filter, output, finish; a clear goes straight to
// finish. The result turns valid in the same cycle as the block returns to
// idle and can take the next item. The single 25x25 multiplier computes
// every product of the item in turn: three gain products, then four partial
// products of the derivative filter in positional mode.
// Output register: a result waiting on a stalled receiver does not block the
// next input transfer; the item then holds in its last step until the
// pending result is taken.
// Reset clears the error history, integral, derivative and output state and
// loads the register defaults (gains zero, limits at full scale).
module pid_position_delta_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ppdc_pkg::pid_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ppdc_pkg::pid_out_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppdc_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic signed [ppdc_pkg::ErrW-1:0] SpanS = ppdc_pkg::ErrW'(ppdc_pkg::WrapSpan);
  localparam logic signed [ppdc_pkg::ErrW-1:0] HalfS = ppdc_pkg::ErrW'(ppdc_pkg::WrapHalf);
  localparam logic signed [ppdc_pkg::ProdW-1:0] Int32Max = ppdc_pkg::ProdW'(64'h7FFF_FFFF);
  localparam logic signed [ppdc_pkg::DoutW-1:0] DerMax =
    ppdc_pkg::DoutW'(64'h0000_7FFF_FFFF_FFFF);

  // configuration
  logic                        mode_q;
  logic [ppdc_pkg::GainW-1:0]  kp_q, ki_q, kd_q;
  logic [14:0]                 max_out_q, max_iout_q;
  logic [15:0]                 isep_q, gamma_q;
  logic                        cfg_we;
  ppdc_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = ppdc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      max_out_q  <= 15'h7FFF;
      max_iout_q <= 15'h7FFF;
      isep_q     <= 16'hFFFF;
      gamma_q    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ppdc_pkg::RegMode:    mode_q     <= pwdata[0];
        ppdc_pkg::RegKp:      kp_q       <= pwdata[23:0];
        ppdc_pkg::RegKi:      ki_q       <= pwdata[23:0];
        ppdc_pkg::RegKd:      kd_q       <= pwdata[23:0];
        ppdc_pkg::RegMaxOut:  max_out_q  <= pwdata[14:0];
        ppdc_pkg::RegMaxIout: max_iout_q <= pwdata[14:0];
        ppdc_pkg::RegISep:    isep_q     <= pwdata[15:0];
        ppdc_pkg::RegGamma:   gamma_q    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ppdc_pkg::RegMode:    prdata = {31'b0, mode_q};
      ppdc_pkg::RegKp:      prdata = {8'b0, kp_q};
      ppdc_pkg::RegKi:      prdata = {8'b0, ki_q};
      ppdc_pkg::RegKd:      prdata = {8'b0, kd_q};
      ppdc_pkg::RegMaxOut:  prdata = {17'b0, max_out_q};
      ppdc_pkg::RegMaxIout: prdata = {17'b0, max_iout_q};
      ppdc_pkg::RegISep:    prdata = {16'b0, isep_q};
      ppdc_pkg::RegGamma:   prdata = {16'b0, gamma_q};
    endcase
  end

  // state
  ppdc_pkg::state_e                  state_q, state_d;
  logic signed [ppdc_pkg::ErrW-1:0]  el_q, el_d, ebl_q, ebl_d;
  logic signed [ppdc_pkg::IntW-1:0]  int_q, int_d;
  logic signed [ppdc_pkg::DerW-1:0]  ld_q, ld_d;
  logic signed [31:0]                oacc_q, oacc_d;
  logic                              out_valid_q, out_valid_d;
  ppdc_pkg::pid_out_t                out_data_q, out_data_d;

  // per-item datapath
  logic signed [ppdc_pkg::ErrW-1:0]   e_q;
  logic signed [ppdc_pkg::DiffW-1:0]  d_q;
  logic signed [ppdc_pkg::Diff2W-1:0] d2_q;
  logic                               keep_q, clr_q;
  logic signed [ppdc_pkg::TW-1:0]     t_q, t_d;
  logic signed [ppdc_pkg::AccW-1:0]   acc_q, acc_d;
  logic signed [ppdc_pkg::DaccW-1:0]  dacc_q, dacc_d;
  logic signed [ppdc_pkg::ProdW-1:0]  prod_q, prod_d;

  logic                               in_acc;
  logic signed [16:0]                 diff;
  logic signed [ppdc_pkg::ErrW-1:0]   err;
  logic [ppdc_pkg::ErrW-1:0]          mag;
  logic signed [ppdc_pkg::DiffW-1:0]  d_new;
  logic signed [ppdc_pkg::Diff2W-1:0] d2_new;

  assign in_stall_o  = (state_q != ppdc_pkg::StIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    diff = $signed({in_data_i.target[15], in_data_i.target})
         - $signed({in_data_i.measured[15], in_data_i.measured});
    err  = $signed({diff[16], diff});
    if (ppdc_pkg::WrapSpan != 0) begin
      if (err > HalfS) begin
        err = err - SpanS;
      end else if (err < -HalfS) begin
        err = err + SpanS;
      end
    end
    mag    = err[ppdc_pkg::ErrW-1] ? ppdc_pkg::ErrW'(-err) : ppdc_pkg::ErrW'(err);
    d_new  = $signed({err[17], err}) - $signed({el_q[17], el_q});
    d2_new = $signed({{3{err[17]}}, err}) - $signed({{2{el_q[17]}}, el_q, 1'b0})
           + $signed({{3{ebl_q[17]}}, ebl_q});
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q    <= err;
      d_q    <= d_new;
      d2_q   <= d2_new;
      keep_q <= (mag <= {2'b0, isep_q});
      clr_q  <= in_data_i.clear;
    end
  end

  // shared multiplier
  logic signed [ppdc_pkg::MulW-1:0] mul_a, mul_b;
  logic [16:0]                      gcomp;
  logic signed [ppdc_pkg::MulW-1:0] e_x, d_x, d2_x;

  assign gcomp = 17'h10000 - {1'b0, gamma_q};
  assign e_x   = $signed({{7{e_q[17]}}, e_q});
  assign d_x   = $signed({{6{d_q[18]}}, d_q});
  assign d2_x  = $signed({{4{d2_q[20]}}, d2_q});

  always_comb begin
    unique case (state_q)
      ppdc_pkg::StMulKd: begin
        mul_a = $signed({1'b0, kd_q});
        mul_b = mode_q ? d2_x : d_x;
      end
      ppdc_pkg::StMulKp: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = mode_q ? d_x : e_x;
      end
      ppdc_pkg::StMulKi: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = e_x;
      end
      ppdc_pkg::StInteg: begin
        mul_a = $signed({1'b0, t_q[23:0]});
        mul_b = $signed({8'b0, gcomp});
      end
      ppdc_pkg::StDer2: begin
        mul_a = $signed({{4{t_q[44]}}, t_q[44:24]});
        mul_b = $signed({8'b0, gcomp});
      end
      ppdc_pkg::StDer3: begin
        mul_a = $signed({1'b0, ld_q[23:0]});
        mul_b = $signed({9'b0, gamma_q});
      end
      ppdc_pkg::StDer4: begin
        mul_a = $signed({ld_q[47], ld_q[47:24]});
        mul_b = $signed({9'b0, gamma_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // sequencer and accumulation
  logic signed [43:0]                isum, ilim;
  logic signed [ppdc_pkg::DoutW-1:0] dout;
  logic signed [ppdc_pkg::AccW-1:0]  lim, clamped;
  logic                              satd;
  logic signed [31:0]                oval, omag;

  assign ilim = $signed({13'b0, max_iout_q, 16'b0});
  assign lim  = $signed({21'b0, max_out_q, 16'b0});
  assign isum = $signed({{12{int_q[31]}}, int_q}) + $signed(prod_q[43:0]);

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    acc_d       = acc_q;
    dacc_d      = dacc_q;
    int_d       = int_q;
    ld_d        = ld_q;
    oacc_d      = oacc_q;
    el_d        = el_q;
    ebl_d       = ebl_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    dout        = mode_q ? $signed({{5{t_q[44]}}, t_q}) : $signed(dacc_q[65:16]);
    satd        = (acc_q > lim) || (acc_q < -lim);
    if (acc_q > lim) begin
      clamped = lim;
    end else if (acc_q < -lim) begin
      clamped = -lim;
    end else begin
      clamped = acc_q;
    end
    oval = clamped[31:0];
    omag = oval[31] ? -oval : oval;

    unique case (state_q)
      ppdc_pkg::StIdle: begin
        if (in_acc) begin
          state_d = in_data_i.clear ? ppdc_pkg::StFinish : ppdc_pkg::StMulKd;
        end
      end
      ppdc_pkg::StMulKd: state_d = ppdc_pkg::StMulKp;
      ppdc_pkg::StMulKp: begin
        t_d     = prod_q[44:0];
        state_d = ppdc_pkg::StMulKi;
      end
      ppdc_pkg::StMulKi: begin
        acc_d   = (mode_q ? $signed({{20{oacc_q[31]}}, oacc_q}) : '0)
                + $signed({{2{prod_q[49]}}, prod_q});
        state_d = ppdc_pkg::StInteg;
      end
      ppdc_pkg::StInteg: begin
        if (mode_q) begin
          if (prod_q > Int32Max) begin
            int_d = Int32Max[31:0];
          end else if (prod_q < -Int32Max) begin
            int_d = -Int32Max[31:0];
          end else begin
            int_d = prod_q[31:0];
          end
        end else if (!keep_q) begin
          int_d = '0;
        end else if (isum > ilim) begin
          int_d = ilim[31:0];
        end else if (isum < -ilim) begin
          int_d = -ilim[31:0];
        end else begin
          int_d = isum[31:0];
        end
        state_d = ppdc_pkg::StDer2;
      end
      ppdc_pkg::StDer2: begin
        acc_d   = acc_q + $signed({{20{int_q[31]}}, int_q});
        dacc_d  = $signed({{16{prod_q[49]}}, prod_q});
        state_d = mode_q ? ppdc_pkg::StDout : ppdc_pkg::StDer3;
      end
      ppdc_pkg::StDer3: begin
        dacc_d  = dacc_q + $signed({prod_q[41:0], 24'b0});
        state_d = ppdc_pkg::StDer4;
      end
      ppdc_pkg::StDer4: begin
        dacc_d  = dacc_q + $signed({{16{prod_q[49]}}, prod_q});
        state_d = ppdc_pkg::StDerSum;
      end
      ppdc_pkg::StDerSum: begin
        dacc_d  = dacc_q + $signed({prod_q[41:0], 24'b0});
        state_d = ppdc_pkg::StDout;
      end
      ppdc_pkg::StDout: begin
        acc_d = acc_q + $signed({{2{dout[49]}}, dout});
        if (dout > DerMax) begin
          ld_d = DerMax[47:0];
        end else if (dout < -DerMax) begin
          ld_d = -DerMax[47:0];
        end else begin
          ld_d = dout[47:0];
        end
        state_d = ppdc_pkg::StFinish;
      end
      ppdc_pkg::StFinish: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          if (clr_q) begin
            el_d                 = '0;
            ebl_d                = '0;
            int_d                = '0;
            oacc_d               = '0;
            out_data_d.drive     = '0;
            out_data_d.saturated = 1'b0;
          end else begin
            oacc_d               = oval;
            ebl_d                = el_q;
            el_d                 = e_q;
            out_data_d.drive     = oval[31] ? -omag[31:16] : omag[31:16];
            out_data_d.saturated = satd;
          end
          state_d = ppdc_pkg::StIdle;
        end
      end
      default: state_d = ppdc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppdc_pkg::StIdle;
      el_q        <= '0;
      ebl_q       <= '0;
      int_q       <= '0;
      ld_q        <= '0;
      oacc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      el_q        <= el_d;
      ebl_q       <= ebl_d;
      int_q       <= int_d;
      ld_q        <= ld_d;
      oacc_q      <= oacc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    t_q        <= t_d;
    acc_q      <= acc_d;
    dacc_q     <= dacc_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: hdl/ppdc_checker.sv
module ppdc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ppdc_pkg::pid_out_t out_data_o
);

  // one item in flight: the input closes right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // a new result only comes out of a cycle in which the input was closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in flight");

  // drive is clamped to a symmetric range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.drive != 16'sh8000)
    else $error("drive outside the symmetric range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed under stall");

endmodule

bind pid_position_delta_controller ppdc_checker u_ppdc_checker (.*);
